/* sv/lzfd_pkg.sv */
// Shared types and constants for the LZ flag-bit decompressor.
package lzfd_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int BYTE_W           = 8;
    localparam int PENDING_W        = 9;
    localparam int STATUS_W         = 3;
    localparam int DIST_W           = 12;
    localparam int WORD_W           = 16;
    localparam int BITS_LEFT_W      = 4;
    localparam int MAX_BIT_STEPS    = 4;   // token + kind + two length bits

    localparam logic [BITS_LEFT_W-1:0] FLAG_BITS_PER_BYTE = 4'd8;
    localparam logic [3:0]             NIBBLE_MASK        = 4'hF;
    localparam logic [PENDING_W-1:0]   LEN_BASE           = 9'd2;
    localparam logic [DIST_W-1:0]      SHORT_ZERO_DIST    = 12'h100;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_KIND,
        PH_SBITS,
        PH_LIT,
        PH_SOFF,
        PH_WHI,
        PH_WLO,
        PH_WLEN
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BUSY,
        ST_IDLE_DRAIN,
        ST_ZERO_OFFSET,
        ST_AFTER_END
    } status_t;

    typedef enum logic {
        ACT_PUSH,
        ACT_DRAIN
    } action_t;

endpackage

/* sv/lzfd_in_if.sv */
// Request channel carrying compressed bytes and drain ticks.
interface lzfd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [lzfd_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output action, output in_byte, input ready);
    modport sink   (input valid, input action, input in_byte, output ready);
endinterface

/* sv/lzfd_out_if.sv */
// Result channel carrying one decompressor result per request.
interface lzfd_out_if;
    logic                           valid;
    logic                           ready;
    logic [lzfd_pkg::BYTE_W-1:0]    out_byte;
    logic                           out_valid;
    logic [lzfd_pkg::PENDING_W-1:0] copy_pending;
    logic                           finished;
    logic [lzfd_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output out_byte, output out_valid, output copy_pending,
                    output finished, output status, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input copy_pending,
                    input finished, input status, output ready);
endinterface

/* sv/lzfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lzfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* sv/lz_flag_bit_decompressor.sv */
// Top level: LZSS-style flag-bit decompressor with a RAM-backed history window.
// Result: registered when its request is accepted, so it appears in the next cycle.
// Throughput: one request (byte push or drain tick) per cycle while results are taken;
//   the single history RAM: a read and a write per cycle; RAW hazards are forwarded.
// Reset: control state clears at once; then a clearing pass writes zero to all
//   WINDOW_DEPTH history entries with the request side held not ready.
module lz_flag_bit_decompressor #(
    parameter int WINDOW_DEPTH = lzfd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lzfd_in_if.sink    stream,
    lzfd_out_if.source result
);
    import lzfd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

    // parser / match state
    logic [BYTE_W-1:0]      flag_bits_reg,       flag_bits_next;
    logic [BITS_LEFT_W-1:0] bits_left_reg,       bits_left_next;
    phase_t                 phase_reg,           phase_next;
    logic [WORD_W-1:0]      held_word_reg,       held_word_next;
    logic [PENDING_W-1:0]   match_remaining_reg, match_remaining_next;
    logic [DIST_W-1:0]      match_distance_reg,  match_distance_next;
    logic [AW-1:0]          write_pos_reg,       write_pos_next;
    logic                   ended_reg,           ended_next;

    // history clearing pass
    logic                   clear_active_reg;
    logic [AW-1:0]          clear_addr_reg;

    // result stage: holds one result and the history write it owes
    logic                   s1_valid_reg;
    logic                   s1_wr_reg;
    logic [AW-1:0]          s1_waddr_reg;
    logic                   s1_use_data_reg;     // literal or forwarded byte
    logic [BYTE_W-1:0]      s1_data_reg;
    logic                   s1_outv_reg;
    logic [PENDING_W-1:0]   s1_pending_reg;
    logic                   s1_finished_reg;
    logic [STATUS_W-1:0]    s1_status_reg;

    // per-request decode
    logic                   accept;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   req_wr;
    logic                   req_use_data;
    logic [BYTE_W-1:0]      req_data;
    logic                   req_outv;
    status_t                req_status;

    // RAM ports
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [BYTE_W-1:0]      ram_wdata;
    logic [BYTE_W-1:0]      ram_rdata;

    logic                   s1_commit;
    logic [BYTE_W-1:0]      s1_byte;
    logic                   fwd_hit;

    assign stream.ready = !clear_active_reg && (!s1_valid_reg || result.ready);
    assign accept       = stream.valid && stream.ready;

    // the stage owes its write when its result leaves
    assign s1_commit = s1_valid_reg && s1_wr_reg && result.ready;
    assign s1_byte   = s1_use_data_reg ? s1_data_reg : ram_rdata;
    // read at the same edge as the pending write to that entry: take the new byte
    assign fwd_hit   = s1_commit && rd_en && (rd_addr == s1_waddr_reg);

    // ---------------------------------------------------------------------------------
    // Next-state decode for one request
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        logic [WORD_W-1:0]    w;
        logic [PENDING_W-1:0] long_len;
        logic                 do_long;
        logic                 fbit;

        flag_bits_next       = flag_bits_reg;
        bits_left_next       = bits_left_reg;
        phase_next           = phase_reg;
        held_word_next       = held_word_reg;
        match_remaining_next = match_remaining_reg;
        match_distance_next  = match_distance_reg;
        write_pos_next       = write_pos_reg;
        ended_next           = ended_reg;
        rd_en                = 1'b0;
        rd_addr              = write_pos_reg - AW'(match_distance_reg);
        req_wr               = 1'b0;
        req_use_data         = 1'b0;
        req_data             = stream.in_byte;
        req_outv             = 1'b0;
        req_status           = ST_OK;
        w                    = {held_word_reg[WORD_W-1:BYTE_W], stream.in_byte};
        long_len             = '0;
        do_long              = 1'b0;
        fbit                 = 1'b0;

        if (stream.action == ACT_DRAIN)
        begin
            if (match_remaining_reg == '0)
            begin
                req_status = ST_IDLE_DRAIN;
            end
            else
            begin
                rd_en                = accept;
                req_wr               = 1'b1;
                req_outv             = 1'b1;
                write_pos_next       = write_pos_reg + 1'b1;
                match_remaining_next = match_remaining_reg - 1'b1;
            end
        end
        else if (ended_reg)
        begin
            req_status = ST_AFTER_END;
        end
        else if (match_remaining_reg != '0)
        begin
            req_status = ST_BUSY;
        end
        else
        begin
            case (phase_reg)
                PH_LIT:
                begin
                    req_outv       = 1'b1;
                    req_wr         = 1'b1;
                    req_use_data   = 1'b1;
                    write_pos_next = write_pos_reg + 1'b1;
                    phase_next     = PH_TOKEN;
                end
                PH_SOFF:
                begin
                    match_remaining_next = LEN_BASE + PENDING_W'(held_word_reg[1:0]);
                    match_distance_next  = (stream.in_byte == '0) ? SHORT_ZERO_DIST
                                                                  : DIST_W'(stream.in_byte);
                    phase_next           = PH_TOKEN;
                end
                PH_WHI:
                begin
                    held_word_next = {stream.in_byte, 8'h00};
                    phase_next     = PH_WLO;
                end
                PH_WLO:
                begin
                    held_word_next = w;
                    if (w == '0)
                    begin
                        ended_next = 1'b1;
                        phase_next = PH_TOKEN;
                    end
                    else if ((w[3:0] & NIBBLE_MASK) != '0)
                    begin
                        do_long  = 1'b1;
                        long_len = PENDING_W'(w[3:0]) + LEN_BASE;
                    end
                    else
                    begin
                        phase_next = PH_WLEN;
                    end
                end
                PH_WLEN:
                begin
                    do_long  = 1'b1;
                    long_len = PENDING_W'(stream.in_byte) + 1'b1;
                end
                default:
                begin
                    // a flag bit is needed and none remain: this is a flag byte
                    flag_bits_next = stream.in_byte;
                    bits_left_next = FLAG_BITS_PER_BYTE;
                end
            endcase

            if (do_long)
            begin
                phase_next = PH_TOKEN;
                if (held_word_next[WORD_W-1:4] == '0)
                begin
                    req_status = ST_ZERO_OFFSET;
                end
                else
                begin
                    match_remaining_next = long_len;
                    match_distance_next  = held_word_next[WORD_W-1:4];
                end
            end

            // consume flag bits, LSB first, while the parser wants one
            if (!ended_next)
            begin
                for (int i = 0; i < MAX_BIT_STEPS; i++)
                begin
                    if ((phase_next inside {PH_TOKEN, PH_KIND, PH_SBITS})
                        && bits_left_next != '0)
                    begin
                        fbit           = flag_bits_next[0];
                        flag_bits_next = flag_bits_next >> 1;
                        bits_left_next = bits_left_next - 1'b1;
                        case (phase_next)
                            PH_TOKEN:
                            begin
                                phase_next = fbit ? PH_KIND : PH_LIT;
                            end
                            PH_KIND:
                            begin
                                if (fbit)
                                begin
                                    held_word_next = '0;
                                    phase_next     = PH_SBITS;
                                end
                                else
                                begin
                                    phase_next = PH_WHI;
                                end
                            end
                            default:
                            begin
                                // bit 2 marks that the first length bit is in
                                if (!held_word_next[2])
                                begin
                                    held_word_next = {13'd0, 1'b1, fbit, 1'b0};
                                end
                                else
                                begin
                                    held_word_next = held_word_next | WORD_W'(fbit);
                                    phase_next     = PH_SOFF;
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_bits_reg       <= '0;
            bits_left_reg       <= '0;
            phase_reg           <= PH_TOKEN;
            held_word_reg       <= '0;
            match_remaining_reg <= '0;
            match_distance_reg  <= '0;
            write_pos_reg       <= '0;
            ended_reg           <= 1'b0;
        end
        else if (accept)
        begin
            flag_bits_reg       <= flag_bits_next;
            bits_left_reg       <= bits_left_next;
            phase_reg           <= phase_next;
            held_word_reg       <= held_word_next;
            match_remaining_reg <= match_remaining_next;
            match_distance_reg  <= match_distance_next;
            write_pos_reg       <= write_pos_next;
            ended_reg           <= ended_next;
        end
    end

    // clearing pass over the history after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_wr_reg    <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_wr_reg    <= req_wr;
        end
        else if (result.ready)
        begin
            s1_valid_reg <= 1'b0;
            s1_wr_reg    <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_waddr_reg    <= write_pos_reg;
            s1_use_data_reg <= req_use_data || fwd_hit;
            s1_data_reg     <= fwd_hit ? s1_byte : req_data;
            s1_outv_reg     <= req_outv;
            s1_pending_reg  <= match_remaining_next;
            s1_finished_reg <= ended_next;
            s1_status_reg   <= req_status;
        end
    end

    // ---------------------------------------------------------------------------------
    // History RAM: clearing pass owns the write port until done
    // ---------------------------------------------------------------------------------
    assign ram_we    = clear_active_reg || s1_commit;
    assign ram_waddr = clear_active_reg ? clear_addr_reg : s1_waddr_reg;
    assign ram_wdata = clear_active_reg ? '0 : s1_byte;

    lzfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign result.valid        = s1_valid_reg;
    assign result.out_byte     = s1_outv_reg ? s1_byte : '0;
    assign result.out_valid    = s1_outv_reg;
    assign result.copy_pending = s1_pending_reg;
    assign result.finished     = s1_finished_reg;
    assign result.status       = s1_status_reg;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    a_no_result_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !s1_valid_reg
    ) else $error("result present during history clearing pass");

    a_end_has_no_match: assert property (
        @(posedge clk) disable iff (!rst_n)
        ended_reg |-> (match_remaining_reg == '0)
    ) else $error("match pending after end of stream");

    a_drain_gives_byte: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && stream.action == ACT_DRAIN && match_remaining_reg != '0)
            |=> (result.valid && result.out_valid)
    ) else $error("pending drain did not produce a byte");

    a_bits_left_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        bits_left_reg <= FLAG_BITS_PER_BYTE
    ) else $error("flag bit count out of range");

endmodule
